FILE: rtl/jhd_pkg.sv
// ----------------------------------------------------------------------------
// jhd_pkg
// Shared types and constants for the JPEG canonical Huffman decoder.
// ----------------------------------------------------------------------------
package jhd_pkg;

  localparam int NUM_LENGTHS = 16;
  localparam int STORE_DEPTH = 256;
  localparam int MAX_SYMBOLS = 256;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_BIT   = 2'd2;

  localparam logic [2:0] ST_SYMBOL     = 3'd0;
  localparam logic [2:0] ST_TABLE_DONE = 3'd1;
  localparam logic [2:0] ST_BAD_CODE   = 3'd2;
  localparam logic [2:0] ST_OVERFLOW   = 3'd3;
  localparam logic [2:0] ST_NOT_LOADED = 3'd4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] table_byte;
    logic       code_bit;
  } in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] symbol;
    logic [4:0] code_length;
    logic [8:0] bytes_read;
  } out_t;

  typedef enum logic [1:0] {
    K_CLEAR,
    K_BYTE,
    K_BIT
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       bit_v;
  } cmd_t;

endpackage

FILE: rtl/jpeg_huffman_decoder_core.sv
// ----------------------------------------------------------------------------
// jpeg_huffman_decoder_core
// JPEG canonical Huffman decoder: table load and bit-serial symbol decode.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall/in_data): one command per transfer:
//   clear table, table byte (16 counts then the symbols) or one code bit.
// Output channel (out_valid/out_stall/out_data): at most one result per
//   command: symbol, table complete, bad code, table overflow, not loaded.
// Throughput: one command per cycle while out_stall holds no result. The
//   canonical ranges are built one length per count byte, and each code
//   bit costs one range compare, plus one read of the symbol RAM when it
//   completes a symbol. An accepted command is queued, then executed at the
//   queue head; its result is registered and presented from then on.
// in_stall rises when the two-entry command queue is full. While out_stall
//   holds a pending result, execution pauses and the queue fills.
// Reset (rst_n low, synchronous) empties the queue and output and clears
//   the load and decode state; the symbol RAM keeps its contents and is
//   only read at entries written by the current load.
// ----------------------------------------------------------------------------
module jpeg_huffman_decoder_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  jhd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output jhd_pkg::out_t out_data
);

  logic          q_valid;
  logic          q_pop;
  jhd_pkg::cmd_t q_cmd;

  jhd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  jhd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: rtl/jhd_front.sv
// ----------------------------------------------------------------------------
// jhd_front
// Accepts input transfers, decodes the opcode and queues commands (2 deep).
// ----------------------------------------------------------------------------
module jhd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  jhd_pkg::in_t  in_data,
  output logic          q_valid,
  output jhd_pkg::cmd_t q_cmd,
  input  logic          q_pop
);

  jhd_pkg::cmd_t slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  jhd_pkg::cmd_t cmd;
  logic          keep;
  logic          push;

  always_comb begin
    cmd.data  = in_data.table_byte;
    cmd.bit_v = in_data.code_bit;
    cmd.kind  = jhd_pkg::K_CLEAR;
    keep      = 1'b1;
    unique case (in_data.opcode)
      jhd_pkg::OP_CLEAR: cmd.kind = jhd_pkg::K_CLEAR;
      jhd_pkg::OP_BYTE:  cmd.kind = jhd_pkg::K_BYTE;
      jhd_pkg::OP_BIT:   cmd.kind = jhd_pkg::K_BIT;
      default:           keep = 1'b0;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (count_r != 2'd0);
  assign q_cmd    = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

FILE: rtl/jhd_back.sv
// ----------------------------------------------------------------------------
// jhd_back
// Executes commands: table load with incremental canonical range build,
// bit-serial decode, symbol store and the output register.
// ----------------------------------------------------------------------------
module jhd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  jhd_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output jhd_pkg::out_t out_data
);

  logic [7:0]  cnt_r   [jhd_pkg::NUM_LENGTHS];
  logic [16:0] first_r [jhd_pkg::NUM_LENGTHS];
  logic [8:0]  offs_r  [jhd_pkg::NUM_LENGTHS];
  logic [7:0]  sym_mem [jhd_pkg::STORE_DEPTH];

  logic [8:0]  pos_r, pos_nxt;
  logic [17:0] code_r, code_nxt;
  logic [11:0] total_r, total_nxt;
  logic        over_r, over_nxt;
  logic        ready_r, ready_nxt;
  logic        failed_r, failed_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [4:0]  len_r, len_nxt;

  logic        ov_r;
  logic [2:0]  ost_r;
  logic [4:0]  olen_r;
  logic [8:0]  obytes_r;
  logic        osym_r;
  logic [7:0]  rdata_r;

  logic        fire;
  logic        res_v;
  logic [2:0]  res_st;
  logic [4:0]  res_len;
  logic [8:0]  res_bytes;
  logic        res_sym;

  logic        cnt_we;
  logic        mem_we;
  logic [7:0]  mem_waddr;
  logic        mem_re;
  logic [7:0]  mem_raddr;

  logic [3:0]  cidx;
  logic [17:0] sum;
  logic [17:0] limit;
  logic [11:0] total_add;
  logic        over_now;
  logic [8:0]  pos_inc;
  logic [15:0] acc_sh;
  logic [4:0]  len_inc;
  logic [3:0]  didx;
  logic [17:0] diff;
  logic        hit;

  assign fire  = q_valid && (!ov_r || !out_stall);
  assign q_pop = fire;

  always_comb begin
    cidx      = pos_r[3:0];
    sum       = code_r + {10'd0, q_cmd.data};
    limit     = 18'd2 << cidx;
    total_add = total_r + {4'd0, q_cmd.data};
    over_now  = over_r || (sum > limit);
    pos_inc   = pos_r + 9'd1;
    acc_sh    = {acc_r[14:0], q_cmd.bit_v};
    len_inc   = len_r + 5'd1;
    didx      = len_r[3:0];
    diff      = {2'b00, acc_sh} - {1'b0, first_r[didx]};
    hit       = (cnt_r[didx] != 8'd0) && !diff[17] && (diff[16:0] < {9'd0, cnt_r[didx]});
    mem_raddr = offs_r[didx][7:0] + diff[7:0];
    mem_waddr = pos_r[7:0] - 8'd16;
  end

  always_comb begin
    pos_nxt    = pos_r;
    code_nxt   = code_r;
    total_nxt  = total_r;
    over_nxt   = over_r;
    ready_nxt  = ready_r;
    failed_nxt = failed_r;
    acc_nxt    = acc_r;
    len_nxt    = len_r;
    res_v      = 1'b0;
    res_st     = jhd_pkg::ST_SYMBOL;
    res_len    = 5'd0;
    res_bytes  = 9'd0;
    res_sym    = 1'b0;
    cnt_we     = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    if (fire) begin
      unique case (q_cmd.kind)
        jhd_pkg::K_CLEAR: begin
          pos_nxt    = 9'd0;
          code_nxt   = 18'd0;
          total_nxt  = 12'd0;
          over_nxt   = 1'b0;
          ready_nxt  = 1'b0;
          failed_nxt = 1'b0;
          acc_nxt    = 16'd0;
          len_nxt    = 5'd0;
        end
        jhd_pkg::K_BYTE: begin
          if (!ready_r && !failed_r) begin
            pos_nxt = pos_inc;
            if (pos_r < 9'(jhd_pkg::NUM_LENGTHS)) begin
              cnt_we    = 1'b1;
              code_nxt  = {sum[16:0], 1'b0};
              total_nxt = total_add;
              over_nxt  = over_now;
              if (cidx == 4'(jhd_pkg::NUM_LENGTHS - 1)) begin
                if (over_now || (total_add > 12'(jhd_pkg::MAX_SYMBOLS))) begin
                  failed_nxt = 1'b1;
                  res_v      = 1'b1;
                  res_st     = jhd_pkg::ST_OVERFLOW;
                  res_bytes  = pos_inc;
                end else if (total_add == 12'd0) begin
                  ready_nxt = 1'b1;
                  res_v     = 1'b1;
                  res_st    = jhd_pkg::ST_TABLE_DONE;
                  res_bytes = pos_inc;
                end
              end
            end else begin
              mem_we = 1'b1;
              if (pos_inc == 9'(jhd_pkg::NUM_LENGTHS) + total_r[8:0]) begin
                ready_nxt = 1'b1;
                res_v     = 1'b1;
                res_st    = jhd_pkg::ST_TABLE_DONE;
                res_bytes = pos_inc;
              end
            end
          end
        end
        jhd_pkg::K_BIT: begin
          res_v = 1'b1;
          if (!ready_r) begin
            res_st = jhd_pkg::ST_NOT_LOADED;
          end else if (hit) begin
            mem_re  = 1'b1;
            res_st  = jhd_pkg::ST_SYMBOL;
            res_sym = 1'b1;
            res_len = len_inc;
            acc_nxt = 16'd0;
            len_nxt = 5'd0;
          end else if (len_inc >= 5'(jhd_pkg::NUM_LENGTHS)) begin
            res_st  = jhd_pkg::ST_BAD_CODE;
            res_len = len_inc;
            acc_nxt = 16'd0;
            len_nxt = 5'd0;
          end else begin
            res_v   = 1'b0;
            acc_nxt = acc_sh;
            len_nxt = len_inc;
          end
        end
        default: begin
          res_v = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= 9'd0;
      code_r   <= 18'd0;
      total_r  <= 12'd0;
      over_r   <= 1'b0;
      ready_r  <= 1'b0;
      failed_r <= 1'b0;
      acc_r    <= 16'd0;
      len_r    <= 5'd0;
      ov_r     <= 1'b0;
    end else begin
      pos_r    <= pos_nxt;
      code_r   <= code_nxt;
      total_r  <= total_nxt;
      over_r   <= over_nxt;
      ready_r  <= ready_nxt;
      failed_r <= failed_nxt;
      acc_r    <= acc_nxt;
      len_r    <= len_nxt;
      if (fire && res_v) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_v) begin
      ost_r    <= res_st;
      olen_r   <= res_len;
      obytes_r <= res_bytes;
      osym_r   <= res_sym;
    end
    if (cnt_we) begin
      cnt_r[cidx]   <= q_cmd.data;
      first_r[cidx] <= code_r[16:0];
      offs_r[cidx]  <= total_r[8:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sym_mem[mem_waddr] <= q_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata_r <= sym_mem[mem_raddr];
    end
  end

  assign out_valid            = ov_r;
  assign out_data.status      = ost_r;
  assign out_data.symbol      = osym_r ? rdata_r : 8'd0;
  assign out_data.code_length = olen_r;
  assign out_data.bytes_read  = obytes_r;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for jpeg_huffman_decoder_core. Streams of clear, table
// byte and code bit commands are driven with random gaps and output stalls.
// Most streams load a well-formed canonical table and then feed codes,
// mostly valid ones. The rest are maximum-size, overflowing, empty, broken
// and noisy streams. Each accepted command runs through a local decoder
// model, and every result is checked against the oldest expected one.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int GAP_MAX = 8;
  localparam int STALL_MAX = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int TARGET_ITEMS = 1200;
  localparam int SETTLE_CYCLES = 8;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  jhd_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  jhd_pkg::out_t out_data;

  always #6 clk = ~clk;

  jpeg_huffman_decoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  typedef struct {
    jhd_pkg::in_t cmd;
    int unsigned  gap;
    bit           hold_for_idle;
  } stim_t;

  stim_t         stim_q[$];
  jhd_pkg::out_t pending_results[$];

  // decoder model state
  logic [7:0]  m_count [jhd_pkg::NUM_LENGTHS];
  logic [7:0]  m_symbols [jhd_pkg::STORE_DEPTH];
  logic [16:0] m_first [jhd_pkg::NUM_LENGTHS];
  logic [8:0]  m_base [jhd_pkg::NUM_LENGTHS];
  logic [8:0]  m_load_pos;
  logic [11:0] m_total;
  logic        m_ready;
  logic        m_failed;
  logic [15:0] m_acc;
  logic [4:0]  m_len;

  function automatic void decoder_clear();
    for (int n = 0; n < jhd_pkg::NUM_LENGTHS; n++) begin
      m_count[n] = '0;
      m_first[n] = '0;
      m_base[n] = '0;
    end
    m_load_pos = '0;
    m_total = '0;
    m_ready = 1'b0;
    m_failed = 1'b0;
    m_acc = '0;
    m_len = '0;
  endfunction

  // returns 1 when the code space or symbol count overflows
  function automatic bit build_ranges();
    int unsigned code;
    int unsigned total;
    bit over;
    code = 0;
    total = 0;
    over = 1'b0;
    for (int n = 0; n < jhd_pkg::NUM_LENGTHS; n++) begin
      m_first[n] = code[16:0];
      m_base[n] = total[8:0];
      code = code + m_count[n];
      total = total + m_count[n];
      if (code > (32'd1 << (n + 1))) over = 1'b1;
      code = code << 1;
    end
    if (total > jhd_pkg::MAX_SYMBOLS) over = 1'b1;
    m_total = total[11:0];
    return over;
  endfunction

  function automatic bit decode_step(input jhd_pkg::in_t x, output jhd_pkg::out_t r);
    int unsigned idx;
    int unsigned diff;
    int unsigned pos;
    r = '0;
    case (x.opcode)
      jhd_pkg::OP_CLEAR: begin
        decoder_clear();
        return 1'b0;
      end
      jhd_pkg::OP_BYTE: begin
        if (m_ready || m_failed) return 1'b0;
        if (m_load_pos < jhd_pkg::NUM_LENGTHS) begin
          m_count[m_load_pos[3:0]] = x.table_byte;
          m_load_pos = m_load_pos + 9'd1;
          if (m_load_pos == jhd_pkg::NUM_LENGTHS) begin
            if (build_ranges()) begin
              m_failed = 1'b1;
              r.status = jhd_pkg::ST_OVERFLOW;
              r.bytes_read = m_load_pos;
              return 1'b1;
            end
            if (m_total == 0) begin
              m_ready = 1'b1;
              r.status = jhd_pkg::ST_TABLE_DONE;
              r.bytes_read = m_load_pos;
              return 1'b1;
            end
          end
          return 1'b0;
        end
        idx = (m_load_pos - jhd_pkg::NUM_LENGTHS) & (jhd_pkg::STORE_DEPTH - 1);
        m_symbols[idx[7:0]] = x.table_byte;
        m_load_pos = m_load_pos + 9'd1;
        if (m_load_pos == jhd_pkg::NUM_LENGTHS + m_total) begin
          m_ready = 1'b1;
          r.status = jhd_pkg::ST_TABLE_DONE;
          r.bytes_read = m_load_pos;
          return 1'b1;
        end
        return 1'b0;
      end
      jhd_pkg::OP_BIT: begin
        if (!m_ready) begin
          r.status = jhd_pkg::ST_NOT_LOADED;
          return 1'b1;
        end
        m_acc = {m_acc[14:0], x.code_bit};
        m_len = m_len + 5'd1;
        idx = (m_len - 1) & (jhd_pkg::NUM_LENGTHS - 1);
        if (m_count[idx[3:0]] != 0 && {1'b0, m_acc} >= m_first[idx[3:0]]) begin
          diff = m_acc - m_first[idx[3:0]];
          if (diff < m_count[idx[3:0]]) begin
            pos = (m_base[idx[3:0]] + diff) & (jhd_pkg::STORE_DEPTH - 1);
            r.status = jhd_pkg::ST_SYMBOL;
            r.symbol = m_symbols[pos[7:0]];
            r.code_length = m_len;
            m_acc = '0;
            m_len = '0;
            return 1'b1;
          end
        end
        if (m_len >= jhd_pkg::NUM_LENGTHS) begin
          r.status = jhd_pkg::ST_BAD_CODE;
          r.code_length = m_len;
          m_acc = '0;
          m_len = '0;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  // ---------------- driver ----------------
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    jhd_pkg::out_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid && decode_step(in_data, r)) pending_results.push_back(r);
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (stim_q.size() != 0 &&
                   !(stim_q[0].hold_for_idle && pending_results.size() != 0)) begin
        in_valid <= 1'b1;
        in_data <= stim_q[0].cmd;
        gap_left <= stim_q[0].gap;
        stim_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- monitor ----------------
  int unsigned stall_left = 0;
  int unsigned results_seen = 0;
  int unsigned fail_count = 0;
  int unsigned n_symbol = 0, n_done = 0, n_over = 0, n_bad = 0, n_unloaded = 0;

  always @(posedge clk) begin
    jhd_pkg::out_t want;
    int unsigned pause;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        case (out_data.status)
          jhd_pkg::ST_SYMBOL:     n_symbol++;
          jhd_pkg::ST_TABLE_DONE: n_done++;
          jhd_pkg::ST_OVERFLOW:   n_over++;
          jhd_pkg::ST_BAD_CODE:   n_bad++;
          default:                n_unloaded++;
        endcase
        if (pending_results.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: status %0d symbol 0x%02h length %0d bytes %0d",
                     out_data.status, out_data.symbol, out_data.code_length,
                     out_data.bytes_read);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status || out_data.symbol !== want.symbol ||
              out_data.code_length !== want.code_length ||
              out_data.bytes_read !== want.bytes_read) begin
            if (fail_count < 10)
              $display("result %0d: expected status %0d symbol 0x%02h length %0d bytes %0d, %s",
                       results_seen, want.status, want.symbol, want.code_length,
                       want.bytes_read,
                       $sformatf("got status %0d symbol 0x%02h length %0d bytes %0d",
                                 out_data.status, out_data.symbol, out_data.code_length,
                                 out_data.bytes_read));
            fail_count++;
          end
        end
        pause = ((results_seen % 200) < 40) ? 0 : $urandom_range(0, STALL_MAX);
      end else if (stall_left > 0) begin
        pause = stall_left - 1;
      end else if ((results_seen % 200) >= 40 && $urandom_range(0, 7) == 0) begin
        pause = $urandom_range(1, STALL_MAX);
      end else begin
        pause = 0;
      end
      stall_left <= pause;
      out_stall <= (pause != 0);
    end
  end

  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  // ---------------- stimulus ----------------
  bit          quiet;
  bit          hold_next;
  int unsigned n_items = 0;
  int unsigned n_tables = 0;
  logic [7:0]  tbl_counts [jhd_pkg::NUM_LENGTHS];
  int unsigned enc_len [jhd_pkg::STORE_DEPTH];
  int unsigned enc_code [jhd_pkg::STORE_DEPTH];
  int unsigned enc_n;

  task automatic add(input logic [1:0] op, input logic [7:0] b, input logic bt);
    stim_t s;
    s.cmd.opcode = op;
    s.cmd.table_byte = b;
    s.cmd.code_bit = bt;
    s.gap = quiet ? 0 : $urandom_range(0, GAP_MAX);
    s.hold_for_idle = hold_next;
    hold_next = 1'b0;
    stim_q.push_back(s);
    if (op != OP_NOP) n_items++;
  endtask

  // clear, then the 16 counts; also builds the encoder's code list
  task automatic send_counts();
    int unsigned code;
    int unsigned k;
    code = 0;
    k = 0;
    add(jhd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    for (int n = 0; n < jhd_pkg::NUM_LENGTHS; n++) begin
      add(jhd_pkg::OP_BYTE, tbl_counts[n], 1'($urandom_range(0, 1)));
      for (int j = 0; j < tbl_counts[n]; j++) begin
        if (k < jhd_pkg::STORE_DEPTH) begin
          enc_len[k] = n + 1;
          enc_code[k] = code + j;
        end
        k++;
      end
      code = (code + tbl_counts[n]) << 1;
    end
    enc_n = (k > jhd_pkg::STORE_DEPTH) ? jhd_pkg::STORE_DEPTH : k;
    n_tables++;
  endtask

  task automatic send_symbols();
    for (int k = 0; k < enc_n; k++)
      add(jhd_pkg::OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_codes(input int unsigned count);
    int unsigned k;
    int unsigned run;
    int unsigned ones;
    for (int c = 0; c < count; c++) begin
      if (enc_n != 0 && $urandom_range(0, 4) != 0) begin
        k = $urandom_range(0, enc_n - 1);
        for (int b = enc_len[k] - 1; b >= 0; b--)
          add(jhd_pkg::OP_BIT, 8'($urandom_range(0, 255)), enc_code[k][b]);
      end else begin
        run = $urandom_range(1, 18);
        ones = $urandom_range(0, 3);
        for (int b = 0; b < run; b++)
          add(jhd_pkg::OP_BIT, 8'($urandom_range(0, 255)),
              (ones == 0) ? 1'b1 : 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 19) == 0)
        add(jhd_pkg::OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 29) == 0)
        add(OP_NOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic build_stimulus();
    int unsigned roll;
    int unsigned budget;
    int unsigned code;
    int unsigned space;
    int unsigned lim;
    int unsigned n_max_tables;
    int unsigned pick;
    n_max_tables = 0;

    // directed: decode before load, unused opcode, empty table, late byte and a bit after it
    quiet = 1'b1;
    hold_next = 1'b0;
    add(jhd_pkg::OP_BIT, 8'hFF, 1'b1);
    add(jhd_pkg::OP_BIT, 8'h00, 1'b0);
    add(OP_NOP, 8'hFF, 1'b1);
    add(jhd_pkg::OP_CLEAR, 8'h00, 1'b0);
    for (int n = 0; n < jhd_pkg::NUM_LENGTHS; n++) add(jhd_pkg::OP_BYTE, 8'h00, n[0]);
    add(jhd_pkg::OP_BYTE, 8'hFF, 1'b1);
    add(jhd_pkg::OP_BIT, 8'h00, 1'b1);

    hold_next = 1'b1;
    while (n_items < TARGET_ITEMS) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) hold_next = 1'b1;
      roll = $urandom_range(0, 19);
      if (roll <= 13) begin
        budget = ($urandom_range(0, 11) == 0) ? jhd_pkg::MAX_SYMBOLS : $urandom_range(1, 24);
        code = 0;
        for (int n = 0; n < jhd_pkg::NUM_LENGTHS; n++) begin
          space = (1 << (n + 1)) - code;
          lim = (space < budget) ? space : budget;
          if (lim > 255) lim = 255;
          tbl_counts[n] = '0;
          if (lim != 0 && $urandom_range(0, 2) == 0) tbl_counts[n] = 8'($urandom_range(1, lim));
          if (lim != 0 && lim == space && $urandom_range(0, 3) == 0) tbl_counts[n] = 8'(space);
          budget -= tbl_counts[n];
          code = (code + tbl_counts[n]) << 1;
        end
        send_counts();
        send_symbols();
        send_codes($urandom_range(4, 30));
      end else if (roll <= 15) begin
        for (int n = 0; n < jhd_pkg::NUM_LENGTHS; n++)
          tbl_counts[n] = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 255)) : 8'd0;
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          tbl_counts[0] = 8'($urandom_range(3, 255));
        end else if (pick == 1) begin
          for (int n = 0; n < jhd_pkg::NUM_LENGTHS; n++) tbl_counts[n] = '0;
          tbl_counts[8] = 8'd255;
          tbl_counts[9] = 8'($urandom_range(2, 255));
        end else begin
          pick = $urandom_range(0, 6);
          tbl_counts[pick] = 8'($urandom_range((1 << (pick + 1)) + 1, 255));
        end
        send_counts();
        enc_n = 0;
        for (int j = 0; j < $urandom_range(1, 4); j++)
          add(jhd_pkg::OP_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_codes($urandom_range(1, 3));
      end else if (roll == 16 && n_max_tables < 3) begin
        n_max_tables++;
        for (int n = 0; n < jhd_pkg::NUM_LENGTHS; n++) tbl_counts[n] = '0;
        if ($urandom_range(0, 1) == 0) begin
          tbl_counts[7] = 8'd255;
          tbl_counts[8] = 8'd1;
        end else begin
          tbl_counts[14] = 8'd1;
          tbl_counts[15] = 8'd2;
        end
        send_counts();
        send_symbols();
        send_codes($urandom_range(10, 30));
      end else if (roll == 17) begin
        add(jhd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        for (int j = 0; j < $urandom_range(1, 20); j++)
          add(jhd_pkg::OP_BYTE, 8'($urandom_range(0, 20)), 1'($urandom_range(0, 1)));
        enc_n = 0;
        send_codes($urandom_range(1, 2));
      end else if (roll == 18) begin
        for (int j = 0; j < $urandom_range(1, 10); j++)
          add(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else begin
        for (int n = 0; n < jhd_pkg::NUM_LENGTHS; n++) tbl_counts[n] = '0;
        send_counts();
        send_codes($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    bit timed_out;
    timed_out = 1'b0;
    decoder_clear();
    build_stimulus();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (!timed_out && (stim_q.size() != 0 || in_valid || pending_results.size() != 0)) begin
      @(posedge clk);
      timed_out = (idle_cycles >= IDLE_LIMIT);
    end
    if (!timed_out) repeat (SETTLE_CYCLES) @(posedge clk);
    if (timed_out)
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      fail_count++;
    end
    $display("run: %0d commands over %0d table loads, %0d results checked, %0d mismatches",
             n_items, n_tables, results_seen, fail_count);
    $display("results: %0d symbols, %0d tables done, %0d overflows, %0d bad codes, %0d unloaded",
             n_symbol, n_done, n_over, n_bad, n_unloaded);
    if (!timed_out && fail_count == 0)
      $display("PASS jpeg_huffman_decoder_core");
    else
      $display("FAIL jpeg_huffman_decoder_core");
    $finish;
  end

endmodule

FILE: jpeg_huffman_decoder_core.f
rtl/jhd_pkg.sv
rtl/jhd_front.sv
rtl/jhd_back.sv
rtl/jpeg_huffman_decoder_core.sv
verif/tb_top.sv
